>>> sv/clns_pkg.sv
package clns_pkg;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_PUT_CHAR = 2'd0,
      OP_GOTO     = 2'd1,
      OP_INIT     = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   // Control register indexes
   typedef enum logic [1:0] {
      CSR_LINES_MODE      = 2'd0,
      CSR_LINE_TWO_BASE   = 2'd1,
      CSR_DISPLAY_CONTROL = 2'd2,
      CSR_ENTRY_MODE      = 2'd3
   } csr_index_type;

   // Special characters
   localparam logic [7:0] CHAR_FORM_FEED = 8'h0C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

   // Display commands
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_CURSOR_LEFT  = 8'h10;
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
   localparam logic [7:0] CMD_SET_ADDRESS  = 8'h80;

   // Wake sequence nibbles
   localparam logic [3:0] NIB_WAKE      = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

   // Waits in microseconds
   localparam logic [13:0] WAIT_POWER_US = 14'd15000;
   localparam logic [12:0] WAIT_WAKE_US  = 13'd5000;
   localparam logic [12:0] WAIT_CLEAR_US = 13'd2000;

   // Init sequence layout
   localparam int         STEP_W         = 4;
   localparam logic [3:0] INIT_WAKE_LAST = 4'd2;  // last wake 3 with 5 ms wait
   localparam logic [3:0] INIT_FOUR_BIT  = 4'd3;
   localparam logic [3:0] INIT_BYTES_AT  = 4'd4;
   localparam logic [3:0] INIT_LAST      = 4'd11;

   // Register reset values
   localparam logic [1:0] LINES_MODE_RST      = 2'd2;
   localparam logic [6:0] LINE_TWO_BASE_RST   = 7'd64;
   localparam logic [7:0] DISPLAY_CONTROL_RST = 8'd12;
   localparam logic [7:0] ENTRY_MODE_RST      = 8'd6;

   // Work queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] lines_mode;
      logic [6:0] line_two_base;
      logic [7:0] display_control;
      logic [7:0] entry_mode;
   } cfg_type;

   // One classified job: either a single byte or the init sequence
   typedef struct packed {
      logic       is_init;
      logic [7:0] data_byte;
      logic       rs;
      logic       clear_wait;
   } job_type;

   typedef struct packed {
      logic [3:0]  nibble;
      logic        rs;
      logic [13:0] wait_before;
      logic [12:0] wait_after;
      logic        last;
   } nib_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> sv/clns_front.sv
module clns_front
   import clns_pkg::*;
(
   input  logic       req_push,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_column,
   input  logic [7:0] req_row,
   input  cfg_type    cfg,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   logic       job_valid;
   logic [7:0] row_base;
   logic [7:0] goto_addr;

   // Goto address wraps at 8 bits
   assign row_base  = (req_row == 8'd1) ? 8'd0 : {1'b0, cfg.line_two_base};
   assign goto_addr = row_base + req_column - 8'd1;

   // Classify the request into one job
   always_comb begin
      job_valid        = 1'b1;
      q_job.is_init    = 1'b0;
      q_job.data_byte  = req_char_code;
      q_job.rs         = 1'b0;
      q_job.clear_wait = 1'b0;
      unique case (opcode_type'(req_opcode))
         OP_PUT_CHAR: begin
            priority if (req_char_code == CHAR_FORM_FEED) begin
               q_job.data_byte  = CMD_CLEAR;
               q_job.clear_wait = 1'b1;
            end else if (req_char_code == CHAR_NEWLINE) begin
               q_job.data_byte = CMD_SET_ADDRESS | {1'b0, cfg.line_two_base};
            end else if (req_char_code == CHAR_BACKSPACE) begin
               q_job.data_byte = CMD_CURSOR_LEFT;
            end else begin
               q_job.rs = 1'b1;
            end
         end
         OP_GOTO: begin
            q_job.data_byte = CMD_SET_ADDRESS | goto_addr;
         end
         OP_INIT: begin
            q_job.is_init = 1'b1;
         end
         OP_NONE: begin
            job_valid = 1'b0;
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
   end

   // Drop unused opcodes and requests made while the queue is full; enqueue the rest
   assign q_push = req_push & ~q_full & job_valid;

endmodule

>>> sv/clns_queue.sv
module clns_queue
   import clns_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      wr_job,
   input  logic         pop,
   output job_type      rd_job,
   output q_status_type status
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign rd_job       = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

>>> sv/clns_back.sv
module clns_back
   import clns_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  job_type      q_job,
   input  q_status_type q_status,
   output logic         q_pop,
   input  logic         out_pop,
   output logic         out_valid,
   output nib_type      out_nib
);

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   job_type             job_ff, job_in;
   logic                out_valid_ff, out_valid_in;
   nib_type             out_ff, out_in;
   nib_type             cur;
   logic                can_load;
   logic                emit;
   logic [STEP_W-1:0]   init_pos;
   logic [7:0]          init_byte;

   assign can_load = ~out_valid_ff | out_pop;
   assign emit     = busy_ff & can_load;
   assign init_pos = step_ff - INIT_BYTES_AT;

   // Pick the setup byte of the init sequence
   always_comb begin
      unique case (init_pos[2:1])
         2'd0:    init_byte = CMD_FUNCTION_SET | {4'd0, cfg.lines_mode, 2'd0};
         2'd1:    init_byte = cfg.display_control;
         2'd2:    init_byte = CMD_CLEAR;
         default: init_byte = cfg.entry_mode;
      endcase
   end

   // Form the nibble for the current step
   always_comb begin
      cur.rs          = 1'b0;
      cur.wait_before = '0;
      cur.wait_after  = '0;
      if (job_ff.is_init) begin
         cur.last = (step_ff == INIT_LAST);
         if (step_ff < INIT_BYTES_AT) begin
            cur.nibble = (step_ff == INIT_FOUR_BIT) ? NIB_FOUR_BIT : NIB_WAKE;
            if (step_ff == '0) begin
               cur.wait_before = WAIT_POWER_US;
            end
            if (step_ff <= INIT_WAKE_LAST) begin
               cur.wait_after = WAIT_WAKE_US;
            end
         end else begin
            cur.nibble = init_pos[0] ? init_byte[3:0] : init_byte[7:4];
         end
      end else begin
         cur.last   = step_ff[0];
         cur.rs     = job_ff.rs;
         cur.nibble = step_ff[0] ? job_ff.data_byte[3:0] : job_ff.data_byte[7:4];
         if (step_ff[0] & job_ff.clear_wait) begin
            cur.wait_after = WAIT_CLEAR_US;
         end
      end
   end

   // Take the next job when idle or on the last nibble of this one
   assign q_pop = ~q_status.empty & (~busy_ff | (emit & cur.last));

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      job_in       = job_ff;
      out_valid_in = out_valid_ff & ~out_pop;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = cur;
         step_in      = step_ff + 1'b1;
         if (cur.last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         step_in = '0;
         job_in  = q_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold job and result words
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_nib   = out_ff;

endmodule

>>> sv/char_lcd_nibble_sequencer_core.sv
// Character LCD request sequencer for a 4-bit bus. Each request word becomes
// nibble words, high nibble first: two for a character or goto, twelve for init.
// The back end emits one nibble per cycle unless a result waits to be popped;
// a two-entry work queue lets the front keep taking requests while results
// wait to be popped. Unused opcode 3 is dropped.
// Control registers are to be written only while the block is idle.
module char_lcd_nibble_sequencer_core
   import clns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_column,
   input  logic [7:0]  req_row,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_nibble,
   output logic        rsp_register_select,
   output logic [13:0] rsp_wait_before_us,
   output logic [12:0] rsp_wait_after_us,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         q_push, q_pop;
   job_type      q_wr_job, q_rd_job;
   q_status_type q_status;
   logic         out_valid;
   nib_type      out_nib;

   // Apply control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINES_MODE:      cfg_in.lines_mode      = csr_wdata[1:0];
            CSR_LINE_TWO_BASE:   cfg_in.line_two_base   = csr_wdata[6:0];
            CSR_DISPLAY_CONTROL: cfg_in.display_control = csr_wdata;
            CSR_ENTRY_MODE:      cfg_in.entry_mode      = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lines_mode      <= LINES_MODE_RST;
         cfg_ff.line_two_base   <= LINE_TWO_BASE_RST;
         cfg_ff.display_control <= DISPLAY_CONTROL_RST;
         cfg_ff.entry_mode      <= ENTRY_MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clns_front u_front (
      .req_push      (req_push),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_column    (req_column),
      .req_row       (req_row),
      .cfg           (cfg_ff),
      .q_full        (q_status.full),
      .q_push        (q_push),
      .q_job         (q_wr_job)
   );

   clns_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (q_wr_job),
      .pop    (q_pop),
      .rd_job (q_rd_job),
      .status (q_status)
   );

   clns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_job     (q_rd_job),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .out_pop   (rsp_pop),
      .out_valid (out_valid),
      .out_nib   (out_nib)
   );

   assign req_full            = q_status.full;
   assign rsp_empty           = ~out_valid;
   assign rsp_nibble          = out_nib.nibble;
   assign rsp_register_select = out_nib.rs;
   assign rsp_wait_before_us  = out_nib.wait_before;
   assign rsp_wait_after_us   = out_nib.wait_after;
   assign rsp_last            = out_nib.last;

`ifndef SYNTHESIS
   // Data writes never carry waits
   a_data_no_wait: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_register_select) |->
         (rsp_wait_before_us == 14'd0 && rsp_wait_after_us == 13'd0))
      else $error("data nibble carries a wait");

   // Power-on wait only on a wake command nibble
   a_power_wait: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_wait_before_us != 14'd0) |->
         (rsp_nibble == NIB_WAKE && !rsp_register_select && !rsp_last))
      else $error("power-on wait on wrong nibble");

   // Nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("result queue not empty after reset");
`endif

endmodule
